// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the LRN core modules.
// Every assertion is clocked on aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate implication: the consequent holds in the same cycle as the antecedent.
`define LRN_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: the consequent holds in the cycle after the antecedent.
`define LRN_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lrn_pkg.sv =====
// Package for the cross-channel LRN core: sizes, payload and control types,
// and the constant table of exp2 roots. No dependencies.
`timescale 1ns / 1ps

package lrn_pkg;

    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_IDX_W   = $clog2(WINDOW_MAX);
    localparam int MAX_OUT     = 8;
    localparam int OUT_CNT_W   = $clog2(MAX_OUT + 1);
    localparam int SUM_W       = 40;
    localparam int CNT_W       = 16;
    localparam int D_W         = 43;
    localparam int MAG_W       = SAMPLE_BITS + 31;

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SCALE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_EXPONENT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_K        = 8'd3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_channel;
    } lrn_in_t;

    typedef struct packed {
        logic signed [15:0] normalized;
        logic               last_of_pixel;
    } lrn_out_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_CHECK, ST_MUL_HI, ST_MUL_LO, ST_SUM_D, ST_NORM,
        ST_LOG, ST_EXPO, ST_EXP, ST_SCALE, ST_EMIT, ST_RETIRE, ST_FINISH
    } lrn_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DIV, OP_MUL_HI, OP_MUL_LO, OP_SUM_D, OP_NORM,
        OP_LOG, OP_EXPO, OP_EXP, OP_SCALE, OP_EMIT, OP_RETIRE, OP_CLEAR
    } lrn_op_t;

    typedef struct packed {
        lrn_op_t op;
    } lrn_cmd_t;

    typedef struct packed {
        logic div_done;
        logic norm_done;
        logic iter_done;
        logic more;
        logic out_busy;
    } lrn_status_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v    = v_in;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Entry i holds 2^(2^-(i+1)) in Q1.30, each a truncated root of the one before.
    function automatic logic [16*31-1:0] exp_roots();
        logic [16*31-1:0] tab;
        logic [63:0]      root;
        tab  = '0;
        root = isqrt64(64'd1 << 61);
        for (int i = 0; i < 16; i++) begin
            tab[i*31 +: 31] = root[30:0];
            root = isqrt64(root << 30);
        end
        return tab;
    endfunction

    localparam logic [16*31-1:0] EXP_ROOTS = exp_roots();

endpackage

// ===== rtl/core/lrn_ctrl.sv =====
// Controller for the LRN core: sequences load, divide, per-output power
// evaluation, emission and pixel clear. Depends on lrn_pkg.
`timescale 1ns / 1ps

module lrn_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lrn_pkg::lrn_status_t status,
    input  logic                last_flag,
    output lrn_pkg::lrn_cmd_t   cmd
);
    import lrn_pkg::*;

    lrn_state_t             state_reg, state_next;
    logic [OUT_CNT_W-1:0]   n_reg, n_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIV;
                    n_next     = '0;
                end
            end
            ST_DIV:    if (status.div_done) state_next = ST_CHECK;
            ST_CHECK: begin
                if (status.more && (n_reg < OUT_CNT_W'(MAX_OUT))) state_next = ST_MUL_HI;
                else state_next = ST_FINISH;
            end
            ST_MUL_HI: state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_SUM_D;
            ST_SUM_D:  state_next = ST_NORM;
            ST_NORM:   if (status.norm_done) state_next = ST_LOG;
            ST_LOG:    if (status.iter_done) state_next = ST_EXPO;
            ST_EXPO:   state_next = ST_EXP;
            ST_EXP:    if (status.iter_done) state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_EMIT;
            ST_EMIT:   if (!status.out_busy) state_next = ST_RETIRE;
            ST_RETIRE: begin
                state_next = ST_CHECK;
                n_next     = n_reg + 1'b1;
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.op  = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            ST_DIV:    cmd.op = OP_DIV;
            ST_CHECK:  cmd.op = OP_NONE;
            ST_MUL_HI: cmd.op = OP_MUL_HI;
            ST_MUL_LO: cmd.op = OP_MUL_LO;
            ST_SUM_D:  cmd.op = OP_SUM_D;
            ST_NORM:   cmd.op = OP_NORM;
            ST_LOG:    cmd.op = OP_LOG;
            ST_EXPO:   cmd.op = OP_EXPO;
            ST_EXP:    cmd.op = OP_EXP;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_EMIT:   if (!status.out_busy) cmd.op = OP_EMIT;
            ST_RETIRE: cmd.op = OP_RETIRE;
            ST_FINISH: if (last_flag) cmd.op = OP_CLEAR;
            default:   cmd.op = OP_NONE;
        endcase
    end

`include "assert_macros.svh"

    `LRN_ASSERT_IMP(a_out_limit, 1'b1, n_reg <= OUT_CNT_W'(MAX_OUT), "too many results in one transaction")
    `LRN_ASSERT_NXT(a_load_div, state_reg == ST_IDLE && s_valid, state_reg == ST_DIV, "accepted transaction did not start the divide")
    `LRN_ASSERT_NXT(a_retire_count, state_reg == ST_RETIRE, n_reg == $past(n_reg) + 1'b1, "result count did not advance on retire")

endmodule

// ===== rtl/core/lrn_datapath.sv =====
// Datapath for the LRN core: configuration registers, sample window, square
// sum, divider, log2/exp2 iterations and the output register. Depends on lrn_pkg.
`timescale 1ns / 1ps

module lrn_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  lrn_pkg::lrn_cmd_t            cmd,
    output lrn_pkg::lrn_status_t         status,
    output logic                         last_flag,
    input  lrn_pkg::lrn_in_t             s_data,
    output lrn_pkg::lrn_out_t            m_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         cfg_valid,
    input  logic [lrn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrn_pkg::*;

    // Configuration
    logic [3:0]  wsize_reg;
    logic [31:0] alpha_reg;
    logic [15:0] beta_reg;
    logic [23:0] bias_reg;

    // Pixel state
    logic signed [SAMPLE_BITS-1:0] window_reg [WINDOW_MAX];
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] chan_reg, emit_reg;
    logic             last_reg;

    // Working registers
    logic [4:0]  cnt_reg;
    logic [31:0] quot_reg;
    logic [3:0]  rem_reg;
    logic [55:0] hi_reg, lo_reg;
    logic signed [SAMPLE_BITS-1:0] xc_reg;
    logic [D_W-1:0] d_reg;
    logic [5:0]  p_reg;
    logic [30:0] m_reg;
    logic [15:0] frac_reg;
    logic signed [40:0] e30_reg;
    logic [30:0] r_reg;
    logic [MAG_W-1:0] mag_reg;
    logic        m_valid_reg;
    lrn_out_t    out_reg;

    // Window geometry
    logic [3:0]       w_eff, pre_w, post_w;
    logic [CNT_W-1:0] pending;
    logic [CNT_W:0]   rd_idx;
    logic             rd_ok;
    logic signed [SAMPLE_BITS-1:0] rd_val;
    logic [SAMPLE_BITS-1:0] rd_mag, in_mag, xc_mag;
    logic [2*SAMPLE_BITS-1:0] in_sq, rd_sq;
    logic [SUM_W:0]   sum_add;

    assign w_eff  = (wsize_reg == 4'd0) ? 4'd1 : wsize_reg;
    assign pre_w  = (w_eff - 4'd1) >> 1;
    assign post_w = w_eff - 4'd1 - pre_w;
    assign pending = chan_reg - emit_reg;

    // One read port into the window: the centre sample, or the sample leaving it.
    always_comb begin
        if (cmd.op == OP_RETIRE) rd_idx = {1'b0, pending} - 1'b1 + (CNT_W+1)'(pre_w);
        else                     rd_idx = {1'b0, pending} - 1'b1;
        rd_ok  = rd_idx < (CNT_W+1)'(WINDOW_MAX);
        rd_val = rd_ok ? window_reg[rd_idx[WIN_IDX_W-1:0]] : '0;
    end

    assign in_mag = s_data.sample[SAMPLE_BITS-1] ? (~s_data.sample + 1'b1) : s_data.sample;
    assign rd_mag = rd_val[SAMPLE_BITS-1] ? (~rd_val + 1'b1) : rd_val;
    assign xc_mag = xc_reg[SAMPLE_BITS-1] ? (~xc_reg + 1'b1) : xc_reg;
    assign in_sq  = in_mag * in_mag;
    assign rd_sq  = rd_mag * rd_mag;
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(in_sq);

    // Divider step
    logic [4:0] div_trial;
    assign div_trial = {rem_reg, quot_reg[31]};

    // Shared multiplier for the two halves of alpha/size * sum.
    logic [23:0] mul_b;
    logic [55:0] mul_p;
    assign mul_b = (cmd.op == OP_MUL_HI) ? sum_reg[SUM_W-1:16] : {8'd0, sum_reg[15:0]};
    assign mul_p = quot_reg * mul_b;

    logic [71:0]    d_full;
    logic [D_W-1:0] d_sum;
    assign d_full = {hi_reg, 16'd0} + 72'(lo_reg);
    assign d_sum  = D_W'(d_full[71:30]) + D_W'(bias_reg);

    logic [61:0] m_sq;
    logic [31:0] m_t;
    assign m_sq = m_reg * m_reg;
    assign m_t  = m_sq[61:30];

    logic signed [6:0]  p_m16;
    logic signed [22:0] l16;
    logic signed [40:0] bl;
    assign p_m16 = $signed({1'b0, p_reg}) - 7'sd16;
    assign l16   = {p_m16, frac_reg};
    assign bl    = $signed({1'b0, beta_reg}) * l16;

    logic [15:0] f16;
    logic signed [10:0] ei;
    logic [30:0] root;
    logic [61:0] r_prod;
    assign f16    = e30_reg[29:14];
    assign ei     = e30_reg[40:30];
    assign root   = EXP_ROOTS[cnt_reg[3:0]*31 +: 31];
    assign r_prod = r_reg * root;

    // Final scaling, rounding and saturation.
    logic signed [11:0] sh, rs;
    logic [MAG_W:0]     rnd_sum;
    logic [62:0]        vraw;
    logic [16:0]        vneg;
    lrn_out_t           out_next;
    always_comb begin
        sh      = {ei[10], ei} - 12'sd30;
        rs      = -sh;
        rnd_sum = '0;
        vraw    = '0;
        if (mag_reg == '0) begin
            vraw = '0;
        end else if (sh[11]) begin
            if (rs >= 12'sd48) begin
                vraw = '0;
            end else begin
                rnd_sum = {1'b0, mag_reg} + ((MAG_W+1)'(1) << (rs - 12'sd1));
                vraw    = 63'(rnd_sum >> rs);
            end
        end else if (sh >= 12'sd16) begin
            vraw = 63'd65536;
        end else begin
            vraw = 63'(mag_reg) << sh[3:0];
        end
        vneg = (vraw > 63'd32768) ? 17'd32768 : vraw[16:0];
        if (xc_reg[SAMPLE_BITS-1]) out_next.normalized = 16'(~vneg + 17'd1);
        else out_next.normalized = (vraw > 63'd32767) ? 16'sd32767 : vraw[15:0];
        out_next.last_of_pixel = last_reg && (pending == CNT_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg   <= 4'd5;
            alpha_reg   <= 32'd107374;
            beta_reg    <= 16'd12288;
            bias_reg    <= 24'd65536;
            sum_reg     <= '0;
            chan_reg    <= '0;
            emit_reg    <= '0;
            last_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < WINDOW_MAX; i++) window_reg[i] <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_WINDOW_SIZE:   wsize_reg <= cfg_data[3:0];
                    CFG_ALPHA_SCALE:   alpha_reg <= cfg_data;
                    CFG_BETA_EXPONENT: beta_reg  <= cfg_data[15:0];
                    CFG_BIAS_K:        bias_reg  <= cfg_data[23:0];
                    default: ;
                endcase
            end
            // An emit is only issued once the previous result has gone or is leaving now.
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_LOAD: begin
                    for (int i = WINDOW_MAX - 1; i > 0; i--)
                        window_reg[i] <= window_reg[i-1];
                    window_reg[0] <= s_data.sample;
                    sum_reg  <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                    chan_reg <= chan_reg + 1'b1;
                    last_reg <= s_data.last_channel;
                end
                OP_RETIRE: begin
                    sum_reg  <= (sum_reg > SUM_W'(rd_sq)) ? sum_reg - SUM_W'(rd_sq) : '0;
                    emit_reg <= emit_reg + 1'b1;
                end
                OP_CLEAR: begin
                    for (int i = 0; i < WINDOW_MAX; i++) window_reg[i] <= '0;
                    sum_reg  <= '0;
                    chan_reg <= '0;
                    emit_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                quot_reg <= alpha_reg;
                rem_reg  <= '0;
                cnt_reg  <= '0;
            end
            OP_DIV: begin
                if (div_trial >= {1'b0, w_eff}) begin
                    rem_reg  <= 4'(div_trial - {1'b0, w_eff});
                    quot_reg <= {quot_reg[30:0], 1'b1};
                end else begin
                    rem_reg  <= div_trial[3:0];
                    quot_reg <= {quot_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_MUL_HI: begin
                hi_reg <= mul_p;
                xc_reg <= rd_val;
            end
            OP_MUL_LO: lo_reg <= mul_p;
            OP_SUM_D: begin
                d_reg <= (d_sum == '0) ? D_W'(1) : d_sum;
                p_reg <= 6'(D_W - 1);
            end
            OP_NORM: begin
                if (d_reg[D_W-1]) begin
                    m_reg    <= d_reg[D_W-1 -: 31];
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                end else begin
                    d_reg <= d_reg << 1;
                    p_reg <= p_reg - 1'b1;
                end
            end
            OP_LOG: begin
                frac_reg <= {frac_reg[14:0], m_t[31]};
                m_reg    <= m_t[31] ? m_t[31:1] : m_t[30:0];
                cnt_reg  <= cnt_reg + 1'b1;
            end
            OP_EXPO: begin
                e30_reg <= -bl;
                r_reg   <= 31'd1 << 30;
                cnt_reg <= '0;
            end
            OP_EXP: begin
                if (f16[4'd15 - cnt_reg[3:0]]) r_reg <= r_prod[60:30];
                cnt_reg <= cnt_reg + 1'b1;
            end
            OP_SCALE: mag_reg <= xc_mag * r_reg;
            OP_EMIT:  out_reg <= out_next;
            default: ;
        endcase
    end

    assign status.div_done  = (cnt_reg == 5'd31);
    assign status.norm_done = d_reg[D_W-1];
    assign status.iter_done = (cnt_reg[3:0] == 4'd15);
    assign status.more      = last_reg ? (pending != '0) : (pending > CNT_W'(post_w));
    assign status.out_busy  = m_valid_reg && !m_ready;
    assign last_flag = last_reg;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

`include "assert_macros.svh"

    `LRN_ASSERT_IMP(a_emit_source, $rose(m_valid_reg), $past(cmd.op == OP_EMIT), "stray result")
    `LRN_ASSERT_IMP(a_log_mantissa, cmd.op == OP_LOG, m_reg[30], "log mantissa out of range")
    `LRN_ASSERT_IMP(a_exp_range, cmd.op == OP_EXP, r_reg[30], "exp2 product fell below one")

endmodule

// ===== rtl/core/lrn_across_channels.sv =====
// Cross-channel LRN core: one sample per transaction. An input transaction holds the
// core for a 32-step divide of alpha by the window size, plus per result it releases
// a normalising shift, 16 log2 and 16 exp2 steps, plus any time a result waits in the
// output register. Synchronous active-low reset clears the window, the square sum,
// the counters and restores the register defaults.
`timescale 1ns / 1ps

module lrn_across_channels (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lrn_pkg::lrn_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lrn_pkg::lrn_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lrn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lrn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lrn_pkg::*;

    lrn_cmd_t    cmd;
    lrn_status_t status;
    logic        last_flag;

    assign cfg_ready = 1'b1;

    lrn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .status    (status),
        .last_flag (last_flag),
        .cmd       (cmd)
    );

    lrn_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .last_flag (last_flag),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== verif/lrn_across_channels_tb.sv =====
// Self-checking testbench for the cross-channel LRN core: directed and random traffic with stalls,
// checked against a behavioural predictor. Depends on lrn_pkg and lrn_across_channels.
`timescale 1ns / 1ps

module lrn_across_channels_tb;
    import lrn_pkg::*;

    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_LIMIT    = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    lrn_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    lrn_out_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    lrn_across_channels u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state.
    logic signed [15:0] win_q [WINDOW_MAX];
    logic [39:0] sq_sum;
    logic [15:0] seen_cnt, emit_cnt;
    logic [3:0]  p_win;
    logic [31:0] p_alpha;
    logic [15:0] p_beta;
    logic [23:0] p_k;

    lrn_in_t  samples_pending [$];
    lrn_out_t expected_outputs [$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  hold_sender = 0;
    bit  hold_receiver = 0;
    int  rx_long_stall = 0;

    function automatic logic [63:0] root_of(input logic [63:0] v_in);
        logic [63:0] v, res, b;
        v = v_in;
        res = 0;
        b = 64'd1 << 62;
        while (b > v && b != 0) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] lrn_value(input logic signed [15:0] x, input logic [39:0] s,
                                              input logic [63:0] a_over);
        logic [63:0] hi, lo, d, m, frac, f16, r, root, mag, val;
        longint l16, e30, ei, sh, rs;
        int p;
        hi = a_over * (s >> 16);
        lo = a_over * (s & 40'hFFFF);
        d = (hi >> 14) + ((((hi & 64'h3FFF) << 16) + lo) >> 30) + p_k;
        if (d == 0) d = 1;
        p = 0;
        while ((d >> (p + 1)) != 0) p++;
        m = p >= 30 ? d >> (p - 30) : d << (30 - p);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        l16 = (longint'(p) - 16) * 65536 + longint'(frac);
        e30 = -longint'(p_beta) * l16;
        if (e30 >= 0) ei = e30 >>> 30;
        else ei = -longint'((64'(-e30) + (64'd1 << 30) - 1) >> 30);
        f16 = 64'(e30 - ei * (longint'(1) <<< 30)) >> 14;
        r = 64'd1 << 30;
        root = root_of(64'd1 << 61);
        for (int i = 1; i <= 16; i++) begin
            if ((f16 >> (16 - i)) & 1) r = (r * root) >> 30;
            root = root_of(root << 30);
        end
        mag = (x < 0 ? 64'(-longint'(x)) : 64'(x)) * r;
        if (mag == 0) return 16'd0;
        sh = ei - 30;
        if (sh < 0) begin
            rs = -sh;
            val = rs > 63 ? 0 : (mag + (64'd1 << (rs - 1))) >> rs;
        end else if (sh >= 62 || (mag >> (62 - sh)) != 0) begin
            val = 32768;
        end else begin
            val = mag << sh;
        end
        if (x < 0) begin
            if (val > 32768) val = 32768;
            return 16'(-longint'(val));
        end
        if (val > 32767) val = 32767;
        return val[15:0];
    endfunction

    task automatic predict_sample(input lrn_in_t it);
        int unsigned w, pre, post, pending, age, old, n;
        logic [63:0] a_over, sq, rm;
        lrn_out_t res;
        w = p_win == 0 ? 1 : p_win;
        pre = (w - 1) / 2;
        post = w - 1 - pre;
        a_over = 64'(p_alpha / w);
        for (int i = WINDOW_MAX - 1; i > 0; i--) win_q[i] = win_q[i - 1];
        win_q[0] = it.sample;
        sq = (it.sample < 0 ? 64'(-longint'(it.sample)) : 64'(it.sample));
        sq = sq * sq;
        sq_sum = (64'(sq_sum) + sq > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : 40'(sq_sum + sq);
        seen_cnt = seen_cnt + 16'd1;
        pending = 16'(seen_cnt - emit_cnt);
        n = 0;
        while (n < MAX_OUT && (it.last_channel ? pending > 0 : pending > post)) begin
            age = pending - 1;
            old = pending - 1 + pre;
            res.normalized = lrn_value(age < WINDOW_MAX ? win_q[age] : 16'sd0, sq_sum, a_over);
            res.last_of_pixel = it.last_channel && pending == 1;
            expected_outputs.push_back(res);
            n++;
            if (old < WINDOW_MAX) begin
                rm = win_q[old] < 0 ? 64'(-longint'(win_q[old])) : 64'(win_q[old]);
                rm = rm * rm;
                sq_sum = sq_sum > rm ? 40'(sq_sum - rm) : 40'd0;
            end
            emit_cnt = emit_cnt + 16'd1;
            pending--;
        end
        if (it.last_channel) begin
            foreach (win_q[i]) win_q[i] = '0;
            sq_sum = '0;
            seen_cnt = '0;
            emit_cnt = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Sender: one transaction per handshake, with random gaps.
    int tx_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // Hold the offered transaction.
        end else begin
            if (s_valid) begin
                predict_sample(samples_pending.pop_front());
            end
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (samples_pending.size() > 0 && !hold_sender) begin
                s_valid <= 1'b1;
                s_data <= samples_pending[0];
                tx_gap <= gap_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each result transaction against the oldest expectation.
    int rx_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch("unexpected result", m_data.normalized, 0);
                end else begin
                    if (m_data.normalized !== expected_outputs[0].normalized)
                        report_mismatch("normalized", m_data.normalized,
                                        expected_outputs[0].normalized);
                    if (m_data.last_of_pixel !== expected_outputs[0].last_of_pixel)
                        report_mismatch("last_of_pixel", m_data.last_of_pixel,
                                        expected_outputs[0].last_of_pixel);
                    void'(expected_outputs.pop_front());
                end
            end
            if (rx_long_stall > 0) begin
                rx_long_stall <= rx_long_stall - 1;
                m_ready <= 1'b0;
            end else if (hold_receiver) begin
                rx_long_stall <= 3000;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) rx_gap <= gap_len();
            end
        end
    end

    // Watchdog on cycles with no transaction at all.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("lrn_across_channels_tb NOT OK");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WINDOW_SIZE:   p_win = value[3:0];
            CFG_ALPHA_SCALE:   p_alpha = value;
            CFG_BETA_EXPONENT: p_beta = value[15:0];
            CFG_BIAS_K:        p_k = value[23:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (samples_pending.size() > 0 || s_valid || expected_outputs.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_pixel(input int len, input bit edge_values);
        lrn_in_t it;
        for (int i = 0; i < len; i++) begin
            if (edge_values) begin
                case ($urandom_range(0, 3))
                    0: it.sample = 16'sh7FFF;
                    1: it.sample = 16'sh8000;
                    2: it.sample = 16'sh0000;
                    default: it.sample = 16'($urandom);
                endcase
            end else if ($urandom_range(0, 3) == 0) begin
                it.sample = 16'($urandom);
            end else begin
                it.sample = 16'($urandom_range(0, 1023) - 512);
            end
            it.last_channel = (i == len - 1);
            samples_pending.push_back(it);
        end
    endtask

    initial begin
        int unsigned w_vals [6];
        w_vals = '{5, 1, 15, 0, 2, 8};
        p_win = 5;
        p_alpha = 107374;
        p_beta = 12288;
        p_k = 65536;
        sq_sum = 0;
        seen_cnt = 0;
        emit_cnt = 0;
        foreach (win_q[i]) win_q[i] = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, single-channel pixels, zero input.
        push_pixel(1, 1);
        push_pixel(3, 1);
        push_pixel(6, 1);
        push_pixel(1, 0);
        drain();
        write_reg(CFG_BIAS_K, 0);
        write_reg(CFG_ALPHA_SCALE, 0);
        push_pixel(4, 1);
        drain();
        write_reg(CFG_ALPHA_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_BIAS_K, 24'hFF_FFFF);
        write_reg(CFG_BETA_EXPONENT, 16'hFFFF);
        push_pixel(5, 1);
        drain();

        // Random phases over several settings.
        foreach (w_vals[ph]) begin
            write_reg(CFG_WINDOW_SIZE, w_vals[ph]);
            write_reg(CFG_ALPHA_SCALE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22));
            write_reg(CFG_BETA_EXPONENT, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 16384));
            write_reg(CFG_BIAS_K, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1 << 14, 1 << 18));
            for (int p = 0; p < 4; p++) push_pixel($urandom_range(1, 12), $urandom_range(0, 5) == 0);
            if (ph == 2) begin
                // Long receiver hold-off while the sender keeps offering.
                hold_receiver <= 1'b1;
                @(posedge aclk);
                hold_receiver <= 1'b0;
            end
            if (ph == 4) begin
                // Let some traffic in, then pause the sender until every expected result has come.
                while (expected_outputs.size() == 0) @(posedge aclk);
                hold_sender = 1;
                while (expected_outputs.size() > 0 || s_valid) @(posedge aclk);
                hold_sender = 0;
            end
            drain();
        end

        if (errors == 0)
            $display("lrn_across_channels_tb OK");
        else
            $display("lrn_across_channels_tb NOT OK");
        $finish;
    end
endmodule
